// ===== rtl/ehp_pkg.sv =====
// Package for the elliptic height profile block.
// Holds field widths, reset values and region codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ehp_pkg;
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int AXIS_W         = 32;
   localparam int SLOPE_W        = 24;
   localparam int HEIGHT_W       = 40;
   localparam int REGION_W       = 2;
   localparam logic [SLOPE_W-1:0] SLOPE_RESET = 24'd65536;
   localparam logic [REGION_W-1:0] REGION_OUTER    = 2'd0;
   localparam logic [REGION_W-1:0] REGION_SHOULDER = 2'd1;
   localparam logic [REGION_W-1:0] REGION_CORE     = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/ehp_sqrt_pipe.sv =====
// Pipelined digit-by-digit floor square root, one root bit per register stage.
// Carries a side vector along with each word; uses no package items.
`timescale 1ns / 1ps
`default_nettype none
module ehp_sqrt_pipe #(
   parameter int VPAIRS = 17,
   parameter int ZPAIRS = 0,
   parameter int SIDE_W = 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic [2*VPAIRS-1:0]        in_value,
   input  wire logic [SIDE_W-1:0]          in_side,
   output logic                            out_valid,
   output logic [VPAIRS+ZPAIRS-1:0]        out_root,
   output logic [SIDE_W-1:0]               out_side
);
   localparam int TOTAL = VPAIRS + ZPAIRS;
   localparam int RW    = TOTAL + 2;
   localparam int VW    = 2 * VPAIRS;

   logic [RW-1:0]     rem_ff  [TOTAL];
   logic [TOTAL-1:0]  root_ff [TOTAL];
   logic [VW-1:0]     val_ff  [TOTAL];
   logic [SIDE_W-1:0] side_ff [TOTAL];
   logic [TOTAL-1:0]  vld_ff;

   logic [RW-1:0]     rem_in  [TOTAL];
   logic [TOTAL-1:0]  root_in [TOTAL];

   always_comb begin
      logic [RW-1:0]    rc;
      logic [RW-1:0]    rs;
      logic [RW-1:0]    tr;
      logic [TOTAL-1:0] oc;
      logic [VW-1:0]    vc;
      logic [1:0]       pair;
      logic             take;
      for (int k = 0; k < TOTAL; k++) begin
         if (k == 0) begin
            rc = '0;
            oc = '0;
            vc = in_value;
         end else begin
            rc = rem_ff[k-1];
            oc = root_ff[k-1];
            vc = val_ff[k-1];
         end
         if (TOTAL - 1 - k >= ZPAIRS) begin
            pair = vc[2*(TOTAL-1-k-ZPAIRS) +: 2];
         end else begin
            pair = 2'b00;
         end
         rs   = {rc[RW-3:0], pair};
         tr   = {oc, 2'b01};
         take = (rs >= tr);
         rem_in[k]  = take ? (rs - tr) : rs;
         root_in[k] = {oc[TOTAL-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[TOTAL-2:0], in_valid};
      end
      for (int k = 0; k < TOTAL; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         if (k == 0) begin
            val_ff[k]  <= in_value;
            side_ff[k] <= in_side;
         end else begin
            val_ff[k]  <= val_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[TOTAL-1];
   assign out_root  = root_ff[TOTAL-1];
   assign out_side  = side_ff[TOTAL-1];
endmodule
`default_nettype wire

// ===== rtl/ehp_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Computes the leading quotient bits of num / den for num below twice den; no package use.
`timescale 1ns / 1ps
`default_nettype none
module ehp_div_pipe #(
   parameter int AW     = 32,
   parameter int QB     = 17,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [AW-1:0]     in_num,
   input  wire logic [AW-1:0]     in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [QB-1:0]          out_quot,
   output logic [SIDE_W-1:0]      out_side
);
   logic [AW-1:0]     rem_ff  [QB];
   logic [AW-1:0]     den_ff  [QB];
   logic [QB-1:0]     quot_ff [QB];
   logic [SIDE_W-1:0] side_ff [QB];
   logic [QB-1:0]     vld_ff;

   logic [AW-1:0]     rem_in  [QB];
   logic [QB-1:0]     quot_in [QB];

   always_comb begin
      logic [AW:0]   t;
      logic [AW-1:0] dc;
      logic [QB-1:0] qc;
      logic          take;
      for (int k = 0; k < QB; k++) begin
         if (k == 0) begin
            t  = {1'b0, in_num};
            dc = in_den;
            qc = '0;
         end else begin
            t  = {rem_ff[k-1], 1'b0};
            dc = den_ff[k-1];
            qc = quot_ff[k-1];
         end
         take       = (t >= {1'b0, dc});
         rem_in[k]  = take ? AW'(t - {1'b0, dc}) : AW'(t);
         quot_in[k] = {qc[QB-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[QB-2:0], in_valid};
      end
      for (int k = 0; k < QB; k++) begin
         rem_ff[k]  <= rem_in[k];
         quot_ff[k] <= quot_in[k];
         if (k == 0) begin
            den_ff[k]  <= in_den;
            side_ff[k] <= in_side;
         end else begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[QB-1];
   assign out_quot  = quot_ff[QB-1];
   assign out_side  = side_ff[QB-1];
endmodule
`default_nettype wire

// ===== rtl/elliptic_height_profile_top.sv =====
// Top level of the elliptic height profile pipeline.
// Depends on ehp_pkg, ehp_sqrt_pipe and ehp_div_pipe.
//
// Channel   Ports                                  Handshake
// request   req_half_axis req_peak_height req_dx   start, taken when busy is low
//           req_dy
// response  rsp_height rsp_region rsp_saturated    strobe, one cycle, no back-pressure
// config    csr_wr_data                            csr_wr_en, no wait
//
// One word is taken every cycle while busy is low, before the words ahead of it are through.
// The depth is set by the radius square root, the divider and the two unit-circle square
// roots, each retiring one bit per stage. Reset clears all valid bits and loads the slope
// with one; busy is high only during reset. The receiver cannot stall, so nothing ever waits.
`timescale 1ns / 1ps
`default_nettype none
module elliptic_height_profile_top #(
   parameter int COORD_BITS = ehp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = ehp_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ehp_pkg::AXIS_W-1:0]    req_half_axis,
   input  wire logic [ehp_pkg::AXIS_W-1:0]    req_peak_height,
   input  wire logic [COORD_BITS-1:0]         req_dx,
   input  wire logic [COORD_BITS-1:0]         req_dy,
   output logic                               strobe,
   output logic [ehp_pkg::HEIGHT_W-1:0]       rsp_height,
   output logic [ehp_pkg::REGION_W-1:0]       rsp_region,
   output logic                               rsp_saturated,
   input  wire logic                          csr_wr_en,
   input  wire logic [ehp_pkg::SLOPE_W-1:0]   csr_wr_data
);
   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int AW  = ehp_pkg::AXIS_W;
   localparam int SW  = ehp_pkg::SLOPE_W;
   localparam int HW  = ehp_pkg::HEIGHT_W;
   localparam int RB  = C + 1 + F;
   localparam int PW  = 2 * C + 2;
   localparam int XW  = ((RB > AW) ? RB : AW) + 1;
   localparam int QW  = 2 * F + 2;
   localparam int AP  = AW + F + 2;
   localparam int BP  = AW + F + 1;
   localparam int OP  = SW + RB;
   localparam int EW0 = ((SW + RB - F > AW + 2) ? (SW + RB - F) : (AW + 2)) + 1;
   localparam int EW  = (EW0 > HW + 1) ? EW0 : (HW + 1);
   localparam int S1W = 2 * AW;
   localparam int DVW = RB + AW + 2;
   localparam int S2W = RB + AW + 1;
   localparam int LAT = C + 3 * F + 9;

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   logic [SW-1:0] slope_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= ehp_pkg::SLOPE_RESET;
      end else if (csr_wr_en) begin
         slope_ff <= csr_wr_data;
      end
   end

   // Input and radius-squared stages.
   logic          a_vld_ff, b_vld_ff;
   logic [AW-1:0] a_axis_ff, a_peak_ff, b_axis_ff, b_peak_ff;
   logic [C-1:0]  a_dx_ff, a_dy_ff;
   logic [PW-1:0] b_rsq_ff, rsq_in;

   assign rsq_in = PW'(a_dx_ff) * PW'(a_dx_ff) + PW'(a_dy_ff) * PW'(a_dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
         b_vld_ff <= a_vld_ff;
      end
      a_axis_ff <= req_half_axis;
      a_peak_ff <= req_peak_height;
      a_dx_ff   <= req_dx;
      a_dy_ff   <= req_dy;
      b_rsq_ff  <= rsq_in;
      b_axis_ff <= a_axis_ff;
      b_peak_ff <= a_peak_ff;
   end

   logic           r_vld;
   logic [RB-1:0]  r_root;
   logic [S1W-1:0] r_side;

   ehp_sqrt_pipe #(.VPAIRS(C + 1), .ZPAIRS(F), .SIDE_W(S1W)) u_rad_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(b_vld_ff), .in_value(b_rsq_ff), .in_side({b_axis_ff, b_peak_ff}),
      .out_valid(r_vld), .out_root(r_root), .out_side(r_side)
   );

   // Region decision stage.
   logic          c_vld_ff, c_outer_ff, c_inner_ff;
   logic [RB-1:0] c_diff_ff;
   logic [AW-1:0] c_axis_ff, c_peak_ff, c_r_ff;
   logic [XW-1:0] r_x, a_x;

   assign r_x = XW'(r_root);
   assign a_x = XW'(r_side[S1W-1:AW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= r_vld;
      end
      c_outer_ff <= (r_side[S1W-1:AW] == '0) || (r_x > a_x);
      c_inner_ff <= ((r_x << 1) < a_x);
      c_diff_ff  <= RB'(r_x - a_x);
      c_axis_ff  <= r_side[S1W-1:AW];
      c_peak_ff  <= r_side[AW-1:0];
      c_r_ff     <= AW'(r_root);
   end

   logic           q_vld;
   logic [F:0]     q_quot;
   logic [DVW-1:0] q_side;

   ehp_div_pipe #(.AW(AW), .QB(F + 1), .SIDE_W(DVW)) u_ratio_div (
      .clock(clock), .reset(reset),
      .in_valid(c_vld_ff), .in_num(c_r_ff), .in_den(c_axis_ff),
      .in_side({c_outer_ff, c_inner_ff, c_diff_ff, c_peak_ff}),
      .out_valid(q_vld), .out_quot(q_quot), .out_side(q_side)
   );

   // Ratio squared stage.
   logic           d_vld_ff;
   logic [QW-1:0]  d_qsq_ff, v1, v2;
   logic [DVW-1:0] d_side_ff;
   localparam logic [QW-1:0] ONE_SQ = QW'(1) << (2 * F);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= q_vld;
      end
      d_qsq_ff  <= QW'(q_quot) * QW'(q_quot);
      d_side_ff <= q_side;
   end

   assign v1 = ONE_SQ - d_qsq_ff;
   assign v2 = ONE_SQ - (d_qsq_ff << 2);

   logic           s1_vld, s2_vld;
   logic [F:0]     s1_root, s2_root;
   logic [S2W-1:0] s1_side;
   logic           s2_inner;

   ehp_sqrt_pipe #(.VPAIRS(F + 1), .ZPAIRS(0), .SIDE_W(S2W)) u_shoulder_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(d_vld_ff), .in_value(v1),
      .in_side({d_side_ff[DVW-1], d_side_ff[DVW-3:0]}),
      .out_valid(s1_vld), .out_root(s1_root), .out_side(s1_side)
   );

   ehp_sqrt_pipe #(.VPAIRS(F + 1), .ZPAIRS(0), .SIDE_W(1)) u_core_sqrt (
      .clock(clock), .reset(reset),
      .in_valid(d_vld_ff), .in_value(v2), .in_side(d_side_ff[DVW-2]),
      .out_valid(s2_vld), .out_root(s2_root), .out_side(s2_inner)
   );

   // Product stage.
   logic          g_vld_ff, g_outer_ff, g_inner_ff;
   logic [AP-1:0] g_alfa_ff;
   logic [BP-1:0] g_bravo_ff;
   logic [OP-1:0] g_flank_ff;
   logic [AW-1:0] g_peak_ff;
   logic [AW-1:0] s_peak;
   logic [RB-1:0] s_diff;
   localparam logic [F+1:0] TWO_FX = (F + 2)'(1) << (F + 1);
   localparam logic [F:0]   ONE_FX = (F + 1)'(1) << F;

   assign s_peak = s1_side[AW-1:0];
   assign s_diff = s1_side[RB+AW-1:AW];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= s1_vld && s2_vld;
      end
      g_alfa_ff  <= AP'(s_peak) * AP'(TWO_FX - (F + 2)'(s1_root));
      g_bravo_ff <= BP'(s_peak) * BP'(ONE_FX - s2_root);
      g_flank_ff <= OP'(slope_ff) * OP'(s_diff);
      g_outer_ff <= s1_side[S2W-1];
      g_inner_ff <= s2_inner;
      g_peak_ff  <= s_peak;
   end

   // Selection and saturation stage.
   logic [EW-1:0] alfa_h, bravo_h, flank_h, pick_h;
   logic [ehp_pkg::REGION_W-1:0] pick_region;
   logic          pick_sat;

   assign alfa_h  = EW'(g_alfa_ff >> F);
   assign bravo_h = EW'({g_bravo_ff, 1'b0} >> F);
   assign flank_h = EW'({g_peak_ff, 1'b0}) + EW'(g_flank_ff >> F);

   always_comb begin
      if (g_outer_ff) begin
         pick_h      = flank_h;
         pick_region = ehp_pkg::REGION_OUTER;
      end else if (g_inner_ff) begin
         pick_h      = (bravo_h < alfa_h) ? bravo_h : alfa_h;
         pick_region = ehp_pkg::REGION_CORE;
      end else begin
         pick_h      = alfa_h;
         pick_region = ehp_pkg::REGION_SHOULDER;
      end
      pick_sat = |pick_h[EW-1:HW];
   end

   logic          strobe_ff, sat_ff;
   logic [HW-1:0] height_ff;
   logic [ehp_pkg::REGION_W-1:0] region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= g_vld_ff;
      end
      height_ff <= pick_sat ? {HW{1'b1}} : pick_h[HW-1:0];
      region_ff <= pick_region;
      sat_ff    <= pick_sat;
   end

   assign strobe        = strobe_ff;
   assign rsp_height    = height_ff;
   assign rsp_region    = region_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT strobe)
      else $error("accepted word did not produce a result on time");
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      strobe |-> $past(accept, LAT))
      else $error("result without a matching accepted word");
   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      (strobe && rsp_saturated) |-> (rsp_height == {HW{1'b1}}))
      else $error("saturated result not at maximum height");
   a_sqrt_lockstep: assert property (@(posedge clock) disable iff (reset)
      s1_vld == s2_vld)
      else $error("unit-circle square roots out of step");
`endif
endmodule
`default_nettype wire
